### rtl/gdfw_pkg.sv
package gdfw_pkg;

  localparam logic [1:0] CMD_ADD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_ADD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_WALK       = 2'd2;

  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_VISITED    = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_LIST_FULL  = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] vertex_a;
    logic [2:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] visited_vertex;
    logic       last_of_run;
  } out_item_t;

endpackage

### rtl/gdfw_ram.sv
module gdfw_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/graph_depth_first_walker.sv
// Depth-first walker over a small undirected graph.
// The in_ channel takes one request at a time: add a vertex, add an edge
// between two existing vertices, or walk the graph. in_ready is high only
// while the block is idle. Each add-vertex, add-edge or walk request gives
// its results on the out_ channel through a one-entry output register; the
// final result of a request has last_of_run set. An unused command code
// gives no result. An add-vertex request, or an add-edge request naming an
// unknown vertex, goes from idle straight to S_EMIT, which raises out_valid;
// any other add-edge request passes through S_RDA, S_RDB and, if the edge is
// accepted, S_WRB before S_EMIT. A walk clears the visited marks and emits
// one result per vertex in depth-first preorder; each root tried passes
// S_ROOT, each neighbour slot scanned S_SCAN and S_TEST, each stack pop
// S_POP and each result S_EMIT. The neighbour list RAM has one read port.
// When the receiver holds out_ready low the walk pauses with the next result
// pending and resumes once the output register is free.
// Reset empties the graph; the neighbour memories need no clearing.
module graph_depth_first_walker
  import gdfw_pkg::*;
#(
  parameter int MAX_VERTICES = 8,
  parameter int MAX_DEGREE   = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int TW     = $clog2(MAX_VERTICES + 1);
  localparam int DW     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW     = $clog2(MAX_DEGREE + 1);
  localparam int EW     = (VW > 3) ? VW : 3;
  localparam int KW     = (EW > TW) ? EW : TW;
  localparam int SDEPTH = MAX_VERTICES * (2 ** DW);
  localparam int SAW    = $clog2(SDEPTH);
  localparam int KW_W   = VW + CW;

  localparam logic [TW-1:0] VT_MAX  = TW'(MAX_VERTICES);
  localparam logic [CW:0]   DEG_MAX = (CW + 1)'(MAX_DEGREE);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDA  = 9'b000000010,
    S_RDB  = 9'b000000100,
    S_WRB  = 9'b000001000,
    S_EMIT = 9'b000010000,
    S_ROOT = 9'b000100000,
    S_SCAN = 9'b001000000,
    S_TEST = 9'b010000000,
    S_POP  = 9'b100000000
  } state_t;

  function automatic logic [2:0] low3(input logic [VW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[2:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [TW-1:0]       vt_r, vt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  out_item_t           res_r, res_nxt;
  logic [VW-1:0]       a_r, a_nxt;
  logic [VW-1:0]       b_r, b_nxt;
  logic                same_r, same_nxt;
  logic [CW-1:0]       na_r, na_nxt;
  logic [CW-1:0]       nb_r, nb_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [VW-1:0]       root_r, root_nxt;
  logic [TW-1:0]       count_r, count_nxt;
  logic [VW-1:0]       cur_v_r, cur_v_nxt;
  logic [CW-1:0]       cur_j_r, cur_j_nxt;
  logic [VW-1:0]       depth_r, depth_nxt;

  logic                nt_we;
  logic [VW-1:0]       nt_waddr, nt_raddr;
  logic [CW-1:0]       nt_wdata, nt_q;
  logic                ns_we;
  logic [SAW-1:0]      ns_waddr, ns_raddr;
  logic [VW-1:0]       ns_wdata, ns_q;
  logic                st_we;
  logic [VW-1:0]       st_waddr, st_raddr;
  logic [KW_W-1:0]     st_wdata, st_q;

  logic [KW-1:0]       a_k, b_k, vt_k;
  logic [CW:0]         na1, na2, nb_e;
  logic                list_full;
  logic [TW-1:0]       count_inc;
  logic                last_hit;

  gdfw_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CW)) u_count_ram (
    .clk(clk), .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
    .raddr(nt_raddr), .rdata(nt_q)
  );

  gdfw_ram #(.DEPTH(SDEPTH), .WIDTH(VW)) u_list_ram (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .raddr(ns_raddr), .rdata(ns_q)
  );

  gdfw_ram #(.DEPTH(MAX_VERTICES), .WIDTH(KW_W)) u_stack_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_q)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign a_k       = KW'(in_data.vertex_a);
  assign b_k       = KW'(in_data.vertex_b);
  assign vt_k      = KW'(vt_r);
  assign na1       = (CW + 1)'(na_r) + (CW + 1)'(1);
  assign na2       = (CW + 1)'(na_r) + (CW + 1)'(2);
  assign nb_e      = (CW + 1)'(nt_q);
  assign list_full = same_r ? (na2 > DEG_MAX)
                            : (((CW + 1)'(na_r) >= DEG_MAX) || (nb_e >= DEG_MAX));
  assign count_inc = count_r + TW'(1);
  assign last_hit  = (count_inc == vt_r);

  always_comb begin
    state_nxt     = state_r;
    vt_nxt        = vt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    same_nxt      = same_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    visited_nxt   = visited_r;
    root_nxt      = root_r;
    count_nxt     = count_r;
    cur_v_nxt     = cur_v_r;
    cur_j_nxt     = cur_j_r;
    depth_nxt     = depth_r;

    nt_we    = 1'b0;
    nt_waddr = a_r;
    nt_wdata = '0;
    nt_raddr = cur_v_r;
    ns_we    = 1'b0;
    ns_waddr = {a_r, na_r[DW-1:0]};
    ns_wdata = b_r;
    ns_raddr = {cur_v_r, cur_j_r[DW-1:0]};
    st_we    = 1'b0;
    st_waddr = depth_r;
    st_wdata = {cur_v_r, cur_j_r + CW'(1)};
    st_raddr = depth_r - VW'(1);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        nt_raddr = a_k[VW-1:0];
        if (in_valid) begin
          a_nxt    = a_k[VW-1:0];
          b_nxt    = b_k[VW-1:0];
          same_nxt = (in_data.vertex_a == in_data.vertex_b);
          case (in_data.command)
            CMD_ADD_VERTEX: begin
              state_nxt = S_EMIT;
              if (vt_r == VT_MAX) begin
                res_nxt = '{status: ST_TABLE_FULL, visited_vertex: 3'd0, last_of_run: 1'b1};
              end else begin
                nt_we    = 1'b1;
                nt_waddr = vt_r[VW-1:0];
                nt_wdata = '0;
                vt_nxt   = vt_r + TW'(1);
                res_nxt  = '{status: ST_ACCEPTED, visited_vertex: low3(vt_r[VW-1:0]),
                             last_of_run: 1'b1};
              end
            end
            CMD_ADD_EDGE: begin
              if ((a_k >= vt_k) || (b_k >= vt_k)) begin
                res_nxt   = '{status: ST_UNKNOWN, visited_vertex: 3'd0, last_of_run: 1'b1};
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_RDA;
              end
            end
            CMD_WALK: begin
              if (vt_r == '0) begin
                res_nxt   = '{status: ST_EMPTY, visited_vertex: 3'd0, last_of_run: 1'b1};
                state_nxt = S_EMIT;
              end else begin
                visited_nxt = '0;
                root_nxt    = '0;
                count_nxt   = '0;
                state_nxt   = S_ROOT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RDA: begin
        na_nxt    = nt_q;
        nt_raddr  = b_r;
        state_nxt = S_RDB;
      end

      S_RDB: begin
        if (list_full) begin
          res_nxt   = '{status: ST_LIST_FULL, visited_vertex: 3'd0, last_of_run: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          ns_we     = 1'b1;
          ns_waddr  = {a_r, na_r[DW-1:0]};
          ns_wdata  = b_r;
          nt_we     = 1'b1;
          nt_waddr  = a_r;
          nt_wdata  = na1[CW-1:0];
          nb_nxt    = same_r ? na1[CW-1:0] : nt_q;
          state_nxt = S_WRB;
        end
      end

      S_WRB: begin
        ns_we     = 1'b1;
        ns_waddr  = {b_r, nb_r[DW-1:0]};
        ns_wdata  = a_r;
        nt_we     = 1'b1;
        nt_waddr  = b_r;
        nt_wdata  = nb_r + CW'(1);
        res_nxt   = '{status: ST_ACCEPTED, visited_vertex: 3'd0, last_of_run: 1'b1};
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = res_r.last_of_run ? S_IDLE : S_SCAN;
        end
      end

      S_ROOT: begin
        if (visited_r[root_r]) begin
          root_nxt = root_r + VW'(1);
        end else begin
          visited_nxt[root_r] = 1'b1;
          count_nxt = count_inc;
          cur_v_nxt = root_r;
          cur_j_nxt = '0;
          depth_nxt = '0;
          res_nxt   = '{status: ST_VISITED, visited_vertex: low3(root_r),
                        last_of_run: last_hit};
          state_nxt = S_EMIT;
        end
      end

      S_SCAN: begin
        state_nxt = S_TEST;
      end

      S_TEST: begin
        if (cur_j_r < nt_q) begin
          cur_j_nxt = cur_j_r + CW'(1);
          state_nxt = S_SCAN;
          if (!visited_r[ns_q]) begin
            visited_nxt[ns_q] = 1'b1;
            count_nxt = count_inc;
            st_we     = 1'b1;
            depth_nxt = depth_r + VW'(1);
            cur_v_nxt = ns_q;
            cur_j_nxt = '0;
            res_nxt   = '{status: ST_VISITED, visited_vertex: low3(ns_q),
                          last_of_run: last_hit};
            state_nxt = S_EMIT;
          end
        end else if (depth_r == '0) begin
          root_nxt  = root_r + VW'(1);
          state_nxt = S_ROOT;
        end else begin
          state_nxt = S_POP;
        end
      end

      S_POP: begin
        cur_v_nxt = st_q[KW_W-1:CW];
        cur_j_nxt = st_q[CW-1:0];
        depth_nxt = depth_r - VW'(1);
        state_nxt = S_SCAN;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vt_r        <= vt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    same_r     <= same_nxt;
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    visited_r  <= visited_nxt;
    root_r     <= root_nxt;
    count_r    <= count_nxt;
    cur_v_r    <= cur_v_nxt;
    cur_j_r    <= cur_j_nxt;
    depth_r    <= depth_nxt;
  end

endmodule

### bench/graph_depth_first_walker_tb.sv
`timescale 1ns / 1ps

module graph_depth_first_walker_tb;
  import gdfw_pkg::*;

  localparam int GRAPH_VERTICES = 8;
  localparam int GRAPH_DEGREE   = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 104;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIRECTED_ROWS = 26;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } directed_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int vtx_count;
  int adj_count [GRAPH_VERTICES];
  logic [2:0] adj_list [GRAPH_VERTICES][GRAPH_DEGREE];
  bit seen [GRAPH_VERTICES];
  int dfs_vertex [GRAPH_VERTICES];
  int dfs_next [GRAPH_VERTICES];

  out_item_t request_results[$];
  out_item_t pending_results[$];
  out_item_t oldest;

  int errors;
  int cycles;
  int burst_left;
  int requests_sent;
  int walks_sent;
  int results_checked;
  int ready_mode;
  int mode_left;

  directed_row_t directed [DIRECTED_ROWS] = '{
    '{'{CMD_WALK,       3'd0, 3'd0}, 1'b1, '{ST_EMPTY,      3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd0}, 1'b1, '{ST_UNKNOWN,    3'd0, 1'b1}},
    '{'{CMD_UNUSED,     3'd7, 3'd7}, 1'b0, '{ST_ACCEPTED,   3'd0, 1'b0}},
    '{'{CMD_ADD_VERTEX, 3'd7, 3'd7}, 1'b1, '{ST_ACCEPTED,   3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd7, 3'd7}, 1'b1, '{ST_UNKNOWN,    3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd6}, 1'b1, '{ST_UNKNOWN,    3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd0, 1'b1}},
    '{'{CMD_WALK,       3'd0, 3'd0}, 1'b0, '{ST_ACCEPTED,   3'd0, 1'b0}},
    '{'{CMD_ADD_VERTEX, 3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd1, 1'b1}},
    '{'{CMD_ADD_VERTEX, 3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd2, 1'b1}},
    '{'{CMD_ADD_VERTEX, 3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd3, 1'b1}},
    '{'{CMD_ADD_VERTEX, 3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd4, 1'b1}},
    '{'{CMD_ADD_VERTEX, 3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd5, 1'b1}},
    '{'{CMD_ADD_VERTEX, 3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd6, 1'b1}},
    '{'{CMD_ADD_VERTEX, 3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd7, 1'b1}},
    '{'{CMD_ADD_VERTEX, 3'd5, 3'd2}, 1'b1, '{ST_TABLE_FULL, 3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd7}, 1'b1, '{ST_ACCEPTED,   3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd7, 3'd3}, 1'b1, '{ST_ACCEPTED,   3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd1, 3'd2}, 1'b0, '{ST_ACCEPTED,   3'd0, 1'b0}},
    '{'{CMD_WALK,       3'd0, 3'd0}, 1'b0, '{ST_ACCEPTED,   3'd0, 1'b0}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd0}, 1'b1, '{ST_ACCEPTED,   3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd0}, 1'b1, '{ST_LIST_FULL,  3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd5}, 1'b1, '{ST_ACCEPTED,   3'd0, 1'b1}},
    '{'{CMD_ADD_EDGE,   3'd0, 3'd6}, 1'b1, '{ST_LIST_FULL,  3'd0, 1'b1}},
    '{'{CMD_WALK,       3'd0, 3'd0}, 1'b0, '{ST_ACCEPTED,   3'd0, 1'b0}}
  };

  graph_depth_first_walker #(
    .MAX_VERTICES(GRAPH_VERTICES),
    .MAX_DEGREE  (GRAPH_DEGREE)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void note_result(input out_item_t r);
    request_results.insert(request_results.size(), r);
  endfunction

  function automatic void predict_graph_request(input in_item_t req);
    int a;
    int b;
    int root;
    int depth;
    int top;
    int v;
    int j;
    int w;
    bit full;
    request_results.delete();
    a = int'(req.vertex_a);
    b = int'(req.vertex_b);
    case (req.command)
      CMD_ADD_VERTEX: begin
        if (vtx_count >= GRAPH_VERTICES) begin
          note_result('{ST_TABLE_FULL, 3'd0, 1'b1});
        end else begin
          adj_count[vtx_count] = 0;
          seen[vtx_count] = 1'b0;
          note_result('{ST_ACCEPTED, 3'(vtx_count), 1'b1});
          vtx_count++;
        end
      end
      CMD_ADD_EDGE: begin
        if (a >= vtx_count || b >= vtx_count) begin
          note_result('{ST_UNKNOWN, 3'd0, 1'b1});
        end else begin
          if (a == b) begin
            full = adj_count[a] + 2 > GRAPH_DEGREE;
          end else begin
            full = adj_count[a] >= GRAPH_DEGREE || adj_count[b] >= GRAPH_DEGREE;
          end
          if (full) begin
            note_result('{ST_LIST_FULL, 3'd0, 1'b1});
          end else begin
            adj_list[a][adj_count[a]] = 3'(b);
            adj_count[a]++;
            adj_list[b][adj_count[b]] = 3'(a);
            adj_count[b]++;
            note_result('{ST_ACCEPTED, 3'd0, 1'b1});
          end
        end
      end
      CMD_WALK: begin
        if (vtx_count == 0) begin
          note_result('{ST_EMPTY, 3'd0, 1'b1});
        end else begin
          for (int i = 0; i < GRAPH_VERTICES; i++) seen[i] = 1'b0;
          for (root = 0; root < vtx_count; root++) begin
            if (!seen[root]) begin
              seen[root] = 1'b1;
              note_result('{ST_VISITED, 3'(root), 1'b0});
              dfs_vertex[0] = root;
              dfs_next[0] = 0;
              depth = 1;
              while (depth > 0) begin
                top = depth - 1;
                v = dfs_vertex[top];
                j = dfs_next[top];
                if (j < adj_count[v]) begin
                  w = int'(adj_list[v][j]);
                  dfs_next[top] = j + 1;
                  if (!seen[w] && depth < GRAPH_VERTICES) begin
                    seen[w] = 1'b1;
                    note_result('{ST_VISITED, 3'(w), 1'b0});
                    dfs_vertex[depth] = w;
                    dfs_next[depth] = 0;
                    depth++;
                  end
                end else begin
                  depth--;
                end
              end
            end
          end
          request_results[request_results.size() - 1].last_of_run = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t random_request();
    in_item_t req;
    int pick;
    pick = $urandom_range(0, 99);
    req.vertex_a = 3'($urandom_range(0, 7));
    req.vertex_b = 3'($urandom_range(0, 7));
    if (pick < 8) begin
      req.command = CMD_ADD_VERTEX;
    end else if (pick < 55) begin
      req.command = CMD_ADD_EDGE;
      if (vtx_count > 0 && $urandom_range(0, 9) < 8) begin
        req.vertex_a = 3'($urandom_range(0, vtx_count - 1));
        req.vertex_b = 3'($urandom_range(0, vtx_count - 1));
      end
    end else if (pick < 88) begin
      req.command = CMD_WALK;
    end else begin
      req.command = CMD_UNUSED;
    end
    return req;
  endfunction

  task automatic send_request(input in_item_t req, input bit typed, input out_item_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    requests_sent++;
    if (req.command == CMD_WALK) walks_sent++;
    predict_graph_request(req);
    if (typed) begin
      pending_results.insert(pending_results.size(), res);
    end else begin
      foreach (request_results[k]) begin
        pending_results.insert(pending_results.size(), request_results[k]);
      end
    end
  endtask

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 24) < 4;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status=%0d vertex=%0d last=%0b",
               out_data.status, out_data.visited_vertex, out_data.last_of_run);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_data.status);
          errors++;
        end
        if (out_data.visited_vertex !== oldest.visited_vertex) begin
          $error("visited_vertex: expected %0d, got %0d",
                 oldest.visited_vertex, out_data.visited_vertex);
          errors++;
        end
        if (out_data.last_of_run !== oldest.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b",
                 oldest.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int random_left;
    in_item_t req;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    errors = 0;
    cycles = 0;
    burst_left = 0;
    requests_sent = 0;
    walks_sent = 0;
    results_checked = 0;
    ready_mode = 0;
    mode_left = 0;
    vtx_count = 0;
    for (int i = 0; i < GRAPH_VERTICES; i++) begin
      adj_count[i] = 0;
      seen[i] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[r]) send_request(directed[r].req, directed[r].typed, directed[r].res);

    random_left = RANDOM_REQUESTS;
    while (random_left > 0) begin
      req = random_request();
      send_request(req, 1'b0, '0);
      random_left--;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d graph requests, %0d of them walks, over a graph of %0d vertices.",
             requests_sent, walks_sent, vtx_count);
    $display("Checked %0d results with %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gdfw_pkg.sv
rtl/gdfw_ram.sv
rtl/graph_depth_first_walker.sv
bench/graph_depth_first_walker_tb.sv
